// ----- sv/int_to_decimal_ascii_macros.svh -----
// ----------------------------------------------------------------------------
// int_to_decimal_ascii assertion macros
// Clocked assertion shorthands shared by the checker.
// ----------------------------------------------------------------------------
`ifndef INT_TO_DECIMAL_ASCII_MACROS_SVH
`define INT_TO_DECIMAL_ASCII_MACROS_SVH

// assertion, muted while reset is high
`define ITDA_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// assertion that is also checked during reset
`define ITDA_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/itda_pkg.sv -----
// ----------------------------------------------------------------------------
// itda_pkg
// Types, constants and the double-dabble step of the decimal formatter.
// ----------------------------------------------------------------------------
package itda_pkg;

   localparam int VALUE_W     = 32;
   localparam int CHAR_W      = 8;
   localparam int NUM_DIGITS  = 10;
   localparam int BCD_W       = 4 * NUM_DIGITS;
   localparam int STAGE_BITS  = 8;
   localparam int NUM_DABBLE  = VALUE_W / STAGE_BITS;
   localparam int NUM_STAGES  = NUM_DABBLE + 1;
   localparam int IDX_W       = $clog2(NUM_DIGITS);

   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

   typedef struct packed {
      logic               neg;
      logic [BCD_W-1:0]   bcd;
      logic [VALUE_W-1:0] bin;
   } conv_type;

   typedef struct packed {
      logic             neg;
      logic [BCD_W-1:0] bcd;
   } word_type;

   // STAGE_BITS shift-and-add-3 steps
   function automatic conv_type dabble_stage(input conv_type s);
      conv_type r;
      r = s;
      for (int i = 0; i < STAGE_BITS; i++) begin
         for (int d = 0; d < NUM_DIGITS; d++) begin
            if (r.bcd[d*4 +: 4] >= 4'd5) begin
               r.bcd[d*4 +: 4] = r.bcd[d*4 +: 4] + 4'd3;
            end
         end
         r.bcd = {r.bcd[BCD_W-2:0], r.bin[VALUE_W-1]};
         r.bin = {r.bin[VALUE_W-2:0], 1'b0};
      end
      return r;
   endfunction

endpackage

// ----- sv/int_to_decimal_ascii.sv -----
// ----------------------------------------------------------------------------
// int_to_decimal_ascii
// A word passes the 5-stage BCD pipeline and the serializer before its first
// character shows. The serializer sets the rate, emitting up to 11 characters
// per value one at a time; the pipeline takes a word every cycle unless it is
// stalled. Reset clears all valids and sets signed_mode to 1.
// ----------------------------------------------------------------------------
module int_to_decimal_ascii (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_enable,
   input  logic                            csr_write_data,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [itda_pkg::VALUE_W-1:0]    req_value,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [itda_pkg::CHAR_W-1:0]     rsp_character,
   output logic                            rsp_last
);

   logic               signed_mode_ff, signed_mode_in;
   logic               pipe_valid;
   logic               pipe_ready;
   itda_pkg::word_type pipe_word;

   assign signed_mode_in = csr_write_enable ? csr_write_data : signed_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         signed_mode_ff <= 1'b1;
      end else begin
         signed_mode_ff <= signed_mode_in;
      end
   end

   itda_bcd_pipe u_bcd_pipe (
      .clock       (clock),
      .reset       (reset),
      .signed_mode (signed_mode_ff),
      .in_valid    (req_valid),
      .in_value    (req_value),
      .in_stall    (req_stall),
      .out_valid   (pipe_valid),
      .out_word    (pipe_word),
      .out_ready   (pipe_ready)
   );

   itda_serializer u_serializer (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (pipe_valid),
      .in_word       (pipe_word),
      .in_ready      (pipe_ready),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last)
   );

endmodule

// ----- sv/itda_bcd_pipe.sv -----
// ----------------------------------------------------------------------------
// itda_bcd_pipe
// Sign handling and pipelined binary to BCD conversion with stall.
// ----------------------------------------------------------------------------
module itda_bcd_pipe (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            signed_mode,
   input  logic                            in_valid,
   input  logic [itda_pkg::VALUE_W-1:0]    in_value,
   output logic                            in_stall,
   output logic                            out_valid,
   output itda_pkg::word_type              out_word,
   input  logic                            out_ready
);

   localparam int LAST = itda_pkg::NUM_STAGES - 1;

   itda_pkg::conv_type                     stage_ff [itda_pkg::NUM_STAGES];
   itda_pkg::conv_type                     stage_in [itda_pkg::NUM_STAGES];
   logic [itda_pkg::NUM_STAGES-1:0]        stage_valid_ff;
   logic [itda_pkg::NUM_STAGES-1:0]        stage_valid_in;
   logic [itda_pkg::NUM_STAGES-1:0]        stage_ready;
   logic                                   in_neg;

   always_comb begin
      stage_ready[LAST] = !stage_valid_ff[LAST] || out_ready;
      for (int k = LAST - 1; k >= 0; k--) begin
         stage_ready[k] = !stage_valid_ff[k] || stage_ready[k+1];
      end
   end

   assign in_neg = signed_mode & in_value[itda_pkg::VALUE_W-1];

   always_comb begin
      stage_in[0].neg = in_neg;
      stage_in[0].bcd = '0;
      stage_in[0].bin = in_neg ? (~in_value + 32'd1) : in_value;
      stage_valid_in[0] = stage_ready[0] ? in_valid : stage_valid_ff[0];
      for (int k = 1; k < itda_pkg::NUM_STAGES; k++) begin
         stage_in[k] = itda_pkg::dabble_stage(stage_ff[k-1]);
         stage_valid_in[k] = stage_ready[k] ? stage_valid_ff[k-1] : stage_valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= '0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < itda_pkg::NUM_STAGES; k++) begin
         if (stage_ready[k]) begin
            stage_ff[k] <= stage_in[k];
         end
      end
   end

   assign in_stall     = !stage_ready[0];
   assign out_valid    = stage_valid_ff[LAST];
   assign out_word.neg = stage_ff[LAST].neg;
   assign out_word.bcd = stage_ff[LAST].bcd;

endmodule

// ----- sv/itda_serializer.sv -----
// ----------------------------------------------------------------------------
// itda_serializer
// Emits sign and significant digits of each word as ASCII, one character at a time.
// ----------------------------------------------------------------------------
module itda_serializer (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   input  itda_pkg::word_type              in_word,
   output logic                            in_ready,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [itda_pkg::CHAR_W-1:0]     rsp_character,
   output logic                            rsp_last
);

   logic                                busy_ff, busy_in;
   logic                                neg_ff, neg_in;
   logic [itda_pkg::IDX_W-1:0]          idx_ff, idx_in;
   logic [itda_pkg::BCD_W-1:0]          bcd_ff, bcd_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [itda_pkg::CHAR_W-1:0]         rsp_char_ff, rsp_char_in;
   logic                                rsp_last_ff, rsp_last_in;

   logic                                out_take;
   logic                                emit;
   logic                                emit_last;
   logic                                load;
   logic [itda_pkg::IDX_W-1:0]          msd;
   logic [3:0]                          cur_digit;

   assign out_take  = !rsp_valid_ff || !rsp_stall;
   assign emit      = busy_ff && out_take;
   assign emit_last = !neg_ff && (idx_ff == '0);
   assign in_ready  = !busy_ff || (emit && emit_last);
   assign load      = in_valid && in_ready;
   assign cur_digit = bcd_ff[{idx_ff, 2'b00} +: 4];

   // leading nonzero digit, zero when the value is zero
   always_comb begin
      msd = '0;
      for (int k = 1; k < itda_pkg::NUM_DIGITS; k++) begin
         if (in_word.bcd[k*4 +: 4] != 4'd0) begin
            msd = itda_pkg::IDX_W'(k);
         end
      end
   end

   always_comb begin
      busy_in = busy_ff;
      neg_in  = neg_ff;
      idx_in  = idx_ff;
      bcd_in  = bcd_ff;
      if (emit) begin
         if (neg_ff) begin
            neg_in = 1'b0;
         end else if (idx_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            idx_in = idx_ff - 1'b1;
         end
      end
      if (load) begin
         busy_in = 1'b1;
         neg_in  = in_word.neg;
         idx_in  = msd;
         bcd_in  = in_word.bcd;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      if (out_take) begin
         rsp_valid_in = emit;
         rsp_char_in  = neg_ff ? itda_pkg::CHAR_MINUS
                               : itda_pkg::CHAR_ZERO + {4'd0, cur_digit};
         rsp_last_in  = emit_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff      <= neg_in;
      idx_ff      <= idx_in;
      bcd_ff      <= bcd_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_character = rsp_char_ff;
   assign rsp_last      = rsp_last_ff;

endmodule

// ----- sv/itda_checker.sv -----
// ----------------------------------------------------------------------------
// itda_checker
// Port-level checks on the formatter's result channel.
// ----------------------------------------------------------------------------
`include "int_to_decimal_ascii_macros.svh"

module itda_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input logic [itda_pkg::CHAR_W-1:0]     rsp_character,
   input logic                            rsp_last
);

   logic [itda_pkg::CHAR_W:0] rsp_word;
   logic                      is_minus;
   logic                      is_digit;

   assign rsp_word = {rsp_character, rsp_last};
   assign is_minus = (rsp_character == itda_pkg::CHAR_MINUS);
   assign is_digit = (rsp_character >= itda_pkg::CHAR_ZERO) &&
                     (rsp_character <= itda_pkg::CHAR_ZERO + 8'd9);

   `ITDA_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !rsp_valid, "result valid after reset")
   `ITDA_ASSERT(a_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word), "stalled result word changed")
   `ITDA_ASSERT(a_char_set, clock, reset, rsp_valid |-> is_minus || is_digit, "bad character")
   `ITDA_ASSERT(a_minus_not_last, clock, reset, rsp_valid && is_minus |-> !rsp_last, "minus sign marked last")

endmodule

bind int_to_decimal_ascii itda_checker u_itda_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_character (rsp_character),
   .rsp_last      (rsp_last)
);

// ----- sim/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench for int_to_decimal_ascii
// Sends 32-bit words in signed and unsigned mode, predicts the decimal text
// of each one character by character and checks every character and its
// last flag in order, with random idling on the request and response sides.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned DIGIT_BASE = 10;
   localparam int RAND_PHASES = 6;
   localparam int PHASE_WORDS = 73;

   typedef struct {
      logic [itda_pkg::CHAR_W-1:0] character;
      logic                        last;
   } text_char_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         csr_write_enable = 1'b0;
   logic                         csr_write_data = 1'b0;
   logic                         req_valid = 1'b0;
   logic                         req_stall;
   logic [itda_pkg::VALUE_W-1:0] req_value = '0;
   logic                         rsp_valid;
   logic                         rsp_stall = 1'b0;
   logic [itda_pkg::CHAR_W-1:0]  rsp_character;
   logic                         rsp_last;

   logic [itda_pkg::VALUE_W-1:0] pending_words[$];
   text_char_type                expected_text[$];
   logic                         signed_mode_shadow = 1'b1;
   bit                           no_idle = 1'b0;
   int                           send_gap = 0;
   int                           stall_left = 0;
   int                           mismatch_count = 0;

   int_to_decimal_ascii DUT (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_character    (rsp_character),
      .rsp_last         (rsp_last)
   );

   always #5 clock = ~clock;

   // appends the expected characters of one word, most significant first
   function automatic void predict_decimal_text(input logic [itda_pkg::VALUE_W-1:0] word,
                                                input logic smode);
      logic                         neg;
      logic [itda_pkg::VALUE_W-1:0] mag;
      logic [itda_pkg::CHAR_W-1:0]  rev_digits[itda_pkg::NUM_DIGITS];
      int                           n;
      text_char_type                c;
      neg = smode && word[itda_pkg::VALUE_W-1];
      mag = neg ? (itda_pkg::VALUE_W'(0) - word) : word;
      n = 0;
      do begin
         rev_digits[n] = itda_pkg::CHAR_ZERO + itda_pkg::CHAR_W'(mag % DIGIT_BASE);
         n++;
         mag = mag / DIGIT_BASE;
      end while (mag != 0);
      if (neg) begin
         c.character = itda_pkg::CHAR_MINUS;
         c.last = 1'b0;
         expected_text.push_back(c);
      end
      for (int k = n - 1; k >= 0; k--) begin
         c.character = rev_digits[k];
         c.last = (k == 0);
         expected_text.push_back(c);
      end
   endfunction

   function automatic int idle_length();
      int r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [itda_pkg::VALUE_W-1:0] random_word();
      logic [itda_pkg::VALUE_W-1:0] p;
      p = 1;
      case ($urandom_range(0, 5))
         0, 1: return $urandom;
         2: return $urandom_range(0, 20);
         3: return itda_pkg::VALUE_W'(0) - $urandom_range(1, 20);
         4: begin
            repeat ($urandom_range(0, 9)) p = p * DIGIT_BASE;
            return p + $urandom_range(0, 2) - 1;
         end
         default: return 32'h8000_0000 + $urandom_range(0, 3) - 2;
      endcase
   endfunction

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= 10) $display("%0t: %s", $realtime, msg);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && !req_stall) predict_decimal_text(req_value, signed_mode_shadow);
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               req_valid <= 1'b0;
               send_gap--;
            end else if (pending_words.size() > 0) begin
               req_value <= pending_words.pop_front();
               req_valid <= 1'b1;
               send_gap = idle_length();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      text_char_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_text.size() == 0) begin
               report_mismatch($sformatf("unexpected word: character 0x%02h last %0b",
                                         rsp_character, rsp_last));
            end else begin
               want = expected_text.pop_front();
               if (rsp_character !== want.character)
                  report_mismatch($sformatf("character: expected 0x%02h, got 0x%02h",
                                            want.character, rsp_character));
               if (rsp_last !== want.last)
                  report_mismatch($sformatf("last: expected %0b, got %0b",
                                            want.last, rsp_last));
            end
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
            stall_left = idle_length();
         end
      end
   end

   task automatic write_signed_mode(input logic m);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= m;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      signed_mode_shadow = m;
   endtask

   // hold the sender until every expected character has come out
   task automatic drain();
      while (pending_words.size() > 0 || req_valid || expected_text.size() > 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic send_directed();
      logic [itda_pkg::VALUE_W-1:0] edge_words[12];
      edge_words = '{32'd0, 32'd1, 32'd9, 32'd10, 32'd999_999_999, 32'd1_000_000_000,
                     32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'hFFFF_FFFE,
                     32'hFFFF_FFFF, 32'hAAAA_5555};
      foreach (edge_words[i]) pending_words.push_back(edge_words[i]);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      write_signed_mode(1'b1);
      send_directed();
      drain();
      write_signed_mode(1'b0);
      send_directed();
      drain();
      for (int ph = 0; ph < RAND_PHASES; ph++) begin
         write_signed_mode(ph % 2 == 0);
         no_idle = (ph == 3);
         repeat (PHASE_WORDS) pending_words.push_back(random_word());
         drain();
      end
      no_idle = 1'b0;
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("testbench failed");
      $finish;
   end

endmodule
